FILE: hw/rtl/ploq_pkg.sv
package ploq_pkg;

  localparam int IDX_W = 10;
  localparam int QTY_W = 32;
  localparam int CNT_W = 11;
  localparam int VOL_W = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FILL   = 2'd2;

  // count and volume update for one item
  typedef struct packed {
    logic en;
    logic cnt_inc;
    logic cnt_dec;
    logic vol_add;
    logic vol_sub;
  } tally_op_t;

endpackage

FILE: hw/rtl/ploq_ram.sv
module ploq_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ploq_tally.sv
module ploq_tally (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ploq_pkg::tally_op_t         op,
  input  logic [ploq_pkg::QTY_W-1:0]  qty,
  output logic [ploq_pkg::CNT_W-1:0]  count,
  output logic [ploq_pkg::VOL_W-1:0]  volume
);

  import ploq_pkg::*;

  localparam int SUM_W = VOL_W + 1;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VOL_W-1:0] vol_r, vol_nxt;
  logic [VOL_W-1:0] qty_ext;
  logic [SUM_W-1:0] sum;

  assign qty_ext = {{(VOL_W-QTY_W){1'b0}}, qty};
  assign sum     = {1'b0, vol_r} + {1'b0, qty_ext};

  always_comb begin
    count_nxt = count_r;
    vol_nxt   = vol_r;
    if (op.en) begin
      if (op.cnt_inc && count_r != CNT_MAX) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (op.cnt_dec && count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
      if (op.vol_add) begin
        // saturate at the top of the volume range
        vol_nxt = sum[VOL_W] ? VOL_MAX : sum[VOL_W-1:0];
      end else if (op.vol_sub) begin
        vol_nxt = (vol_r >= qty_ext) ? vol_r - qty_ext : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vol_r   <= '0;
    end else begin
      count_r <= count_nxt;
      vol_r   <= vol_nxt;
    end
  end

  assign count  = count_r;
  assign volume = vol_r;

endmodule

FILE: hw/rtl/price_level_order_queue.sv
// One price level of an order book: a first-in-first-out list of orders
// threaded through a pool of slots, with an order count and share volume.
// Input channel: in_req_type, in_order_index and in_quantity are taken at the
// rising edge where start is high and busy is low. Request types are append
// (link the slot in at the tail, add shares), remove (unlink the slot, subtract
// shares) and fill (subtract executed shares). Other codes, or an append or
// remove with a slot outside the pool, leave the level unchanged.
// Result channel: every item gives exactly one result, the level after the
// step, shown for one cycle with out_strobe high. Busy rises at the accepting
// edge, and out_strobe is busy registered, so the result follows the busy cycle.
// A remove reads the slot's links from the link memories, which register their
// read data, and writes the neighbours' links in the busy cycle. A new item can
// be taken in the cycle its predecessor's result is shown. The receiver cannot
// stall the block.
// Reset (rst_n low at a clock edge) empties the level: no head, no tail, zero
// count and volume. The link memories need no clearing, since a slot's links
// are written when it is appended.
module price_level_order_queue #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [ploq_pkg::IDX_W-1:0]  in_order_index,
  input  logic [ploq_pkg::QTY_W-1:0]  in_quantity,
  output logic                        out_strobe,
  output logic                        out_head_valid,
  output logic [ploq_pkg::IDX_W-1:0]  out_head_index,
  output logic                        out_tail_valid,
  output logic [ploq_pkg::IDX_W-1:0]  out_tail_index,
  output logic [ploq_pkg::CNT_W-1:0]  out_order_count,
  output logic [ploq_pkg::VOL_W-1:0]  out_level_volume
);

  import ploq_pkg::*;

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int LINK_W = SLOT_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic strobe_r;

  logic [1:0]        op_r;
  logic              ok_r;
  logic [SLOT_W-1:0] slot_r;
  logic [QTY_W-1:0]  qty_r;

  logic              head_valid_r, head_valid_nxt;
  logic [SLOT_W-1:0] head_slot_r, head_slot_nxt;
  logic              tail_valid_r, tail_valid_nxt;
  logic [SLOT_W-1:0] tail_slot_r, tail_slot_nxt;

  logic              acc;
  logic              in_pool;
  logic [SLOT_W-1:0] in_slot;

  logic              nx_we, pv_we;
  logic [SLOT_W-1:0] nx_waddr, pv_waddr;
  logic [LINK_W-1:0] nx_wdata, pv_wdata;
  logic [LINK_W-1:0] nx_rdata, pv_rdata;

  tally_op_t tally_op;

  assign busy    = (state_r == ST_EXEC);
  assign acc     = start && !busy;
  assign in_pool = (32'(in_order_index) < POOL_DEPTH);
  assign in_slot = SLOT_W'(in_order_index);

  ploq_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (in_slot),
    .rdata (nx_rdata)
  );

  ploq_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (in_slot),
    .rdata (pv_rdata)
  );

  ploq_tally u_tally (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (tally_op),
    .qty    (qty_r),
    .count  (out_order_count),
    .volume (out_level_volume)
  );

  always_comb begin
    nx_we          = 1'b0;
    nx_waddr       = in_slot;
    nx_wdata       = '0;
    pv_we          = 1'b0;
    pv_waddr       = in_slot;
    pv_wdata       = {tail_valid_r, tail_slot_r};
    head_valid_nxt = head_valid_r;
    head_slot_nxt  = head_slot_r;
    tail_valid_nxt = tail_valid_r;
    tail_slot_nxt  = tail_slot_r;
    tally_op       = '0;
    state_nxt      = state_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_EXEC;
          // append: new slot gets a null next link and the old tail behind it
          if (in_req_type == REQ_APPEND && in_pool) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
          end
        end
      end
      ST_EXEC: begin
        state_nxt   = ST_IDLE;
        tally_op.en = 1'b1;
        case (op_r)
          REQ_APPEND: begin
            if (ok_r) begin
              if (head_valid_r && tail_valid_r) begin
                nx_we    = 1'b1;
                nx_waddr = tail_slot_r;
                nx_wdata = {1'b1, slot_r};
              end
              if (!head_valid_r) begin
                head_valid_nxt = 1'b1;
                head_slot_nxt  = slot_r;
              end
              tail_valid_nxt   = 1'b1;
              tail_slot_nxt    = slot_r;
              tally_op.cnt_inc = 1'b1;
              tally_op.vol_add = 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (ok_r) begin
              // links of the removed slot were read at the accepting edge
              if (pv_rdata[SLOT_W]) begin
                nx_we    = 1'b1;
                nx_waddr = pv_rdata[SLOT_W-1:0];
                nx_wdata = nx_rdata;
              end else begin
                head_valid_nxt = nx_rdata[SLOT_W];
                head_slot_nxt  = nx_rdata[SLOT_W-1:0];
              end
              if (nx_rdata[SLOT_W]) begin
                pv_we    = 1'b1;
                pv_waddr = nx_rdata[SLOT_W-1:0];
                pv_wdata = pv_rdata;
              end else begin
                tail_valid_nxt = pv_rdata[SLOT_W];
                tail_slot_nxt  = pv_rdata[SLOT_W-1:0];
              end
              tally_op.cnt_dec = 1'b1;
              tally_op.vol_sub = 1'b1;
            end
          end
          REQ_FILL: begin
            tally_op.vol_sub = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      strobe_r     <= 1'b0;
      head_valid_r <= 1'b0;
      head_slot_r  <= '0;
      tail_valid_r <= 1'b0;
      tail_slot_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      strobe_r     <= busy;
      head_valid_r <= head_valid_nxt;
      head_slot_r  <= head_slot_nxt;
      tail_valid_r <= tail_valid_nxt;
      tail_slot_r  <= tail_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_req_type;
      ok_r   <= in_pool;
      slot_r <= in_slot;
      qty_r  <= in_quantity;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_head_valid = head_valid_r;
  assign out_head_index = head_valid_r ? IDX_W'(head_slot_r) : '0;
  assign out_tail_valid = tail_valid_r;
  assign out_tail_index = tail_valid_r ? IDX_W'(tail_slot_r) : '0;

endmodule

FILE: hw/rtl/ploq_chk.sv
module ploq_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [ploq_pkg::CNT_W-1:0]  out_order_count,
  input logic [ploq_pkg::VOL_W-1:0]  out_level_volume
);

  // an accepted item occupies exactly one busy cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("accepted item did not raise busy");

  // the result follows the busy cycle
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_strobe)
    else $error("no result after busy cycle");

  // no result without an item in work
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(rst_n) |-> $past(busy))
    else $error("result without an item");

  // level count and volume hold while idle
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> $stable(out_order_count) && $stable(out_level_volume))
    else $error("level changed while idle");

endmodule

bind price_level_order_queue ploq_chk u_ploq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_order_count  (out_order_count),
  .out_level_volume (out_level_volume)
);
